// ===== sv/stereo_voice_mixer_macros.svh =====
// assertion macros for the stereo voice mixer
`ifndef STEREO_VOICE_MIXER_MACROS_SVH
`define STEREO_VOICE_MIXER_MACROS_SVH

// property that holds every cycle out of reset
`define SVM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication, consequent in the next cycle
`define SVM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/svm_pkg.sv =====
// package: constants, types and helpers for the stereo voice mixer
`default_nettype none
package svm_pkg;

  localparam int Voices      = 6;
  localparam int SampleDepth = 4096;
  localparam int AddrW       = $clog2(SampleDepth);
  localparam int VoiceW      = $clog2(Voices + 1);

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_START = 2'd1,
    MODE_MIX   = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_SAT,
    ST_OUT
  } state_t;

  // one voice slot as it moves along the chain
  typedef struct packed {
    logic              active;
    logic [AddrW-1:0]  position;
    logic [12:0]       remaining;
    logic [15:0]       gain;
    logic [15:0]       balance;
  } voice_t;

  // controls shared by every cell
  typedef struct packed {
    logic             shift;
    logic             step;
    logic             load;
    logic             claim;
    logic [AddrW-1:0] addr;
    logic [12:0]      len;
    logic [15:0]      vol;
    logic [15:0]      pan;
  } cell_ctl_t;

  // left pan gain, 17 bits
  function automatic logic [16:0] pan_left(input logic [15:0] pan);
    logic [16:0] g;
    if (pan[15] || pan == 16'd0) g = 17'd32768;
    else g = 17'd32768 - {1'b0, pan};
    return g;
  endfunction

  function automatic logic [16:0] pan_right(input logic [15:0] pan);
    logic [16:0] g;
    if (!pan[15]) g = 17'd32768;
    else g = 17'd32768 - {1'b0, (~pan + 16'd1)};
    return g;
  endfunction

endpackage
`default_nettype wire

// ===== sv/svm_cell.sv =====
// one voice slot cell of the rotating chain
`default_nettype none
module svm_cell
  import svm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cell_ctl_t ctl,
  input  wire logic      prev_free,   // some lower-index cell in the chain is free
  input  wire voice_t    from_prev,
  output voice_t         slot
);

  voice_t slot_r, slot_nxt;
  logic [AddrW:0] pos_inc;

  assign slot = slot_r;
  assign pos_inc = {1'b0, slot_r.position} + 1'b1;

  // claim a free slot or rotate; the head's voice arrives already advanced
  always_comb begin
    slot_nxt = slot_r;
    if (ctl.claim && !slot_r.active && !prev_free) begin
      slot_nxt.active    = 1'b1;
      slot_nxt.position  = ctl.addr;
      slot_nxt.remaining = ctl.len;
      slot_nxt.gain      = ctl.vol;
      slot_nxt.balance   = ctl.pan;
    end else if (ctl.shift) begin
      slot_nxt = from_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  logic unused_ok;
  assign unused_ok = ctl.step ^ ctl.load ^ pos_inc[AddrW];

endmodule
`default_nettype wire

// ===== sv/svm_mac.sv =====
// shared multiply-accumulate: one channel term per cycle, four stages
`default_nettype none
module svm_mac
  import svm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        clear,
  input  wire logic        in_vld,
  input  wire logic        in_right,
  input  wire logic [15:0] sample,
  input  wire logic [15:0] gain,
  input  wire logic [16:0] pan_gain,
  input  wire logic [15:0] master,
  output logic signed [24:0] acc_left,
  output logic signed [24:0] acc_right,
  output logic             busy
);

  logic               s1_vld_r, s2_vld_r, s3_vld_r;
  logic               s1_rt_r, s2_rt_r, s3_rt_r;
  logic signed [32:0] s1_a_r;    // sample * master
  logic        [32:0] s1_b_r;    // gain * pan gain
  logic signed [66:0] s2_r;      // full product
  logic signed [18:0] s3_r;      // term truncated toward zero
  logic signed [66:0] bias2;
  logic signed [66:0] q2;
  logic signed [24:0] accl_r, accr_r;

  assign acc_left  = accl_r;
  assign acc_right = accr_r;
  assign busy = s1_vld_r | s2_vld_r | s3_vld_r;

  // truncate toward zero after dividing by 2^45: negatives are biased up first
  assign bias2 = s2_r[66] ? $signed({22'd0, {45{1'b1}}}) : 67'sd0;
  assign q2 = (s2_r + bias2) >>> 45;

  always_ff @(posedge clk) begin
    s1_a_r <= 33'($signed(sample)) * 33'($signed({1'b0, master}));
    s1_b_r <= 33'(gain) * 33'(pan_gain);
    s2_r   <= 67'(s1_a_r) * 67'($signed({1'b0, s1_b_r}));
    s3_r   <= q2[18:0];
  end

  // valid pipe and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0; s2_vld_r <= 1'b0; s3_vld_r <= 1'b0;
      s1_rt_r <= 1'b0; s2_rt_r <= 1'b0; s3_rt_r <= 1'b0;
      accl_r <= '0; accr_r <= '0;
    end else begin
      s1_vld_r <= in_vld; s2_vld_r <= s1_vld_r; s3_vld_r <= s2_vld_r;
      s1_rt_r <= in_right; s2_rt_r <= s1_rt_r; s3_rt_r <= s2_rt_r;
      if (clear) begin
        accl_r <= '0; accr_r <= '0;
      end else if (s3_vld_r) begin
        if (s3_rt_r) accr_r <= accr_r + 25'(s3_r);
        else accl_r <= accl_r + 25'(s3_r);
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/stereo_voice_mixer.sv =====
// top level: stereo voice mixer with a rotating chain of voice cells
//
//  port group  dir  fields
//  in_*        in   mode, address, sample_left, sample_right, voice_length, volume, pan
//  out_*       out  mix_left, mix_right, playing, started
//  cfg_*       in   master_volume
//
// load, start and unused-mode items pass from input capture through the saturate
// and output states; a mix item first passes each voice through the head cell,
// which feeds one shared multiplier (left, then right); it then drains the multiplier,
// saturates and registers the result. the next input transfer is taken once the
// block is idle again and the output register is empty or being read.
// a voice rotates through the head cell; sample memory read is registered.
// sync active-low reset: voice slots cleared, master volume 32768, sample memory kept.
// the output register holds a result while out_tready is low; input waits.
`default_nettype none
module stereo_voice_mixer
  import svm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // mode[1:0] address[13:2] sample_left[29:14] sample_right[45:30]
  // voice_length[58:46] voice_volume[74:59] voice_pan[90:75]
  input  wire logic [95:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // mix_left[15:0] mix_right[31:16] playing[32] started[33]
  output logic [39:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
`include "stereo_voice_mixer_macros.svh"

  state_t state_r, state_nxt;
  logic [15:0] master_r;
  logic [1:0] mode_r;
  logic [AddrW-1:0] addr_r;
  logic [15:0] sl_r, sr_r, vol_r, pan_r;
  logic [12:0] len_r;
  logic [VoiceW-1:0] cnt_r, cnt_nxt;
  logic [2:0] drain_r, drain_nxt;
  logic playing_r, started_r;
  logic out_vld_r;
  logic [15:0] ml_r, mr_r;
  logic [31:0] mem [SampleDepth];
  logic [31:0] rd_r;
  logic rd_vld_r;
  voice_t rd_voice_r;
  logic acc_vld, acc_rt;
  logic [15:0] acc_smp;
  logic [16:0] acc_pan;
  logic signed [24:0] accl, accr;
  logic mac_busy;
  logic phase_r;

  cell_ctl_t ctl;
  voice_t slots [Voices];
  voice_t head_out;
  logic [Voices:0] free_chain;
  logic [AddrW:0] pos_inc;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) master_r <= 16'd32768;
    else if (cfg_we) master_r <= cfg_wdata;
  end

  // chain of cells, head feeds the tail after advancing
  always_comb begin
    head_out = slots[Voices-1];
    pos_inc = {1'b0, head_out.position} + 1'b1;
    if (head_out.active) begin
      head_out.position = (pos_inc == (AddrW+1)'(SampleDepth)) ? '0 : pos_inc[AddrW-1:0];
      head_out.remaining = head_out.remaining - 13'd1;
      if (head_out.remaining == 13'd0) head_out.active = 1'b0;
    end
  end

  assign free_chain[0] = 1'b0;
  for (genvar i = 0; i < Voices; i++) begin : g_cell
    assign free_chain[i+1] = free_chain[i] | ~slots[i].active;
    svm_cell u_cell (
      .clk, .rst_n, .ctl,
      .prev_free (free_chain[i]),
      .from_prev (i == 0 ? head_out : slots[(i + Voices - 1) % Voices]),
      .slot      (slots[i])
    );
  end

  logic [Voices-1:0] act_bits;
  for (genvar j = 0; j < Voices; j++) begin : g_act
    assign act_bits[j] = slots[j].active;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    drain_nxt = drain_r;
    case (state_r)
      ST_IDLE: if (in_tvalid && in_tready) begin
        state_nxt = (mode_t'(in_tdata[1:0]) == MODE_MIX) ? ST_RUN : ST_SAT;
        cnt_nxt = '0;
      end
      ST_RUN: begin
        if (!phase_r) cnt_nxt = cnt_r;
        else cnt_nxt = cnt_r + 1'b1;
        if (phase_r && cnt_r == VoiceW'(Voices - 1)) begin
          state_nxt = ST_DRAIN;
          drain_nxt = '0;
        end
      end
      ST_DRAIN: begin
        drain_nxt = drain_r + 3'd1;
        if (drain_r == 3'd5) state_nxt = ST_SAT;
      end
      ST_SAT: state_nxt = ST_OUT;
      ST_OUT: if (!out_vld_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // cell controls: each voice holds the head for a left and a right phase
  always_comb begin
    ctl = '0;
    ctl.addr = addr_r;
    ctl.len = len_r;
    ctl.vol = vol_r;
    ctl.pan = pan_r;
    ctl.shift = (state_r == ST_RUN) && phase_r;
    ctl.claim = (state_r == ST_SAT) && (mode_t'(mode_r) == MODE_START) && (len_r != 13'd0);
  end

  // state registers and item capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      drain_r <= '0;
      phase_r <= 1'b0;
      out_vld_r <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      drain_r <= drain_nxt;
      phase_r <= (state_r == ST_RUN) ? ~phase_r : 1'b0;
      rd_vld_r <= (state_r == ST_RUN) && !phase_r;
      if (out_vld_r && out_tready) out_vld_r <= 1'b0;
      if (state_r == ST_OUT && (!out_vld_r || out_tready)) out_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid && in_tready) begin
      mode_r <= in_tdata[1:0];
      addr_r <= in_tdata[2 +: AddrW];
      sl_r <= in_tdata[29:14];
      sr_r <= in_tdata[45:30];
      len_r <= in_tdata[58:46];
      vol_r <= in_tdata[74:59];
      pan_r <= in_tdata[90:75];
      playing_r <= |act_bits;
    end
    if (state_r == ST_SAT) begin
      started_r <= ctl.claim && !(&act_bits);
    end
  end

  // sample memory
  always_ff @(posedge clk) begin
    if (state_r == ST_SAT && mode_t'(mode_r) == MODE_LOAD) mem[addr_r] <= {sr_r, sl_r};
    rd_r <= mem[slots[Voices-1].position];
    rd_voice_r <= slots[Voices-1];
  end

  // feed the multiplier: left term from the registered read, right from its held copy
  logic rd_vld2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) rd_vld2_r <= 1'b0;
    else rd_vld2_r <= rd_vld_r;
  end
  logic [31:0] rd_hold_r;
  voice_t rd_voice_hold_r;
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      rd_hold_r <= rd_r;
      rd_voice_hold_r <= rd_voice_r;
    end
  end
  assign acc_vld = (rd_vld_r && rd_voice_r.active) || (rd_vld2_r && rd_voice_hold_r.active);
  assign acc_rt  = rd_vld2_r;
  assign acc_smp = rd_vld2_r ? rd_hold_r[31:16] : rd_r[15:0];
  assign acc_pan = rd_vld2_r ? pan_right(rd_voice_hold_r.balance) : pan_left(rd_voice_r.balance);

  logic [15:0] acc_gain;
  assign acc_gain = rd_vld2_r ? rd_voice_hold_r.gain : rd_voice_r.gain;

  svm_mac u_mac (
    .clk, .rst_n,
    .clear     (state_r == ST_IDLE),
    .in_vld    (acc_vld),
    .in_right  (acc_rt),
    .sample    (acc_smp),
    .gain      (acc_gain),
    .pan_gain  (acc_pan),
    .master    (master_r),
    .acc_left  (accl),
    .acc_right (accr),
    .busy      (mac_busy)
  );

  // saturate and hold result
  always_ff @(posedge clk) begin
    if (state_r == ST_SAT) begin
      if (mode_t'(mode_r) == MODE_MIX) begin
        ml_r <= (accl > 25'sd32767) ? 16'h7fff : (accl < -25'sd32768) ? 16'h8000 : accl[15:0];
        mr_r <= (accr > 25'sd32767) ? 16'h7fff : (accr < -25'sd32768) ? 16'h8000 : accr[15:0];
      end else begin
        ml_r <= '0;
        mr_r <= '0;
      end
    end
  end

  // input waits while a result is still pending on the output
  assign in_tready = (state_r == ST_IDLE) && (!out_vld_r || out_tready);
  assign out_tvalid = out_vld_r;
  assign out_tdata = {6'd0, started_r, playing_r, mr_r, ml_r};

  logic unused_ok;
  assign unused_ok = pos_inc[AddrW] ^ free_chain[Voices] ^ (|in_tdata[95:91]);

  `SVM_ASSERT(a_ready_idle, !(in_tready && out_vld_r && !out_tready), "ready while result waits")
  `SVM_ASSERT_NEXT(a_mac_done, state_r == ST_SAT, !mac_busy, "mac still busy at saturation")
  `SVM_ASSERT_NEXT(a_out_after, state_r == ST_OUT && (!out_vld_r || out_tready), out_vld_r, "result lost")

endmodule
`default_nettype wire

// ===== bench/stereo_voice_mixer_test.sv =====
// testbench for the stereo voice mixer: directed table, random items, predictor check
`default_nettype none
module stereo_voice_mixer_test;
  import svm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // window of sample memory that is filled, centered on the wrap point
  localparam int FillFrames = 256;
  localparam int FillBase   = SampleDepth - FillFrames / 2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] address;
    logic [15:0] sample_left;
    logic [15:0] sample_right;
    logic [12:0] voice_length;
    logic [15:0] voice_volume;
    logic [15:0] voice_pan;
  } mix_item_t;

  // fields from the top bit down, as in out_tdata[33:0]
  typedef struct packed {
    logic        started;
    logic        playing;
    logic [15:0] mix_right;
    logic [15:0] mix_left;
  } mix_frame_t;

  // one row of the directed table; typed result used only where known
  typedef struct {
    mode_t       mode;
    logic [11:0] address;
    logic [15:0] sample_left;
    logic [15:0] sample_right;
    logic [12:0] voice_length;
    logic [15:0] voice_volume;
    logic [15:0] voice_pan;
    bit          typed;
    mix_frame_t  frame;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  stereo_voice_mixer dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [31:0] frame_mem [SampleDepth];
  bit          slot_on [Voices];
  int unsigned slot_pos [Voices];
  int unsigned slot_left [Voices];
  logic [15:0] slot_gain [Voices];
  logic [15:0] slot_pan [Voices];
  logic [15:0] master_gain = 16'd32768;

  mix_frame_t  frames_due [$];
  int          mismatches = 0;
  bit          steady = 1'b0;
  int          rx_hold = 0;

  // gap length: mostly short, a few long, none in steady phases
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 4);
  endfunction

  function automatic longint voice_share(logic [15:0] smp, logic [15:0] gain, longint pan_g);
    longint p;
    p = longint'($signed(smp)) * longint'(gain) * pan_g * longint'(master_gain);
    return p / (longint'(1) << 45);
  endfunction

  function automatic logic [15:0] clamp16(longint s);
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return s[15:0];
  endfunction

  // advance the mixer state by one item and return its frame
  function automatic mix_frame_t mixer_step(mix_item_t it);
    mix_frame_t f;
    longint acc_l, acc_r, pan, gl, gr;
    logic [31:0] fr;
    f = '0;
    acc_l = 0;
    acc_r = 0;
    for (int v = 0; v < Voices; v++) if (slot_on[v]) f.playing = 1'b1;
    case (it.mode)
      MODE_LOAD: frame_mem[it.address] = {it.sample_right, it.sample_left};
      MODE_START: begin
        if (it.voice_length != 0) begin
          for (int v = 0; v < Voices; v++) begin
            if (!slot_on[v] && !f.started) begin
              slot_on[v] = 1'b1;
              slot_pos[v] = it.address;
              slot_left[v] = it.voice_length;
              slot_gain[v] = it.voice_volume;
              slot_pan[v] = it.voice_pan;
              f.started = 1'b1;
            end
          end
        end
      end
      MODE_MIX: begin
        for (int v = 0; v < Voices; v++) begin
          if (slot_on[v]) begin
            fr = frame_mem[slot_pos[v]];
            pan = longint'($signed(slot_pan[v]));
            gl = (pan <= 0) ? 32768 : 32768 - pan;
            gr = (pan >= 0) ? 32768 : 32768 + pan;
            acc_l += voice_share(fr[15:0], slot_gain[v], gl);
            acc_r += voice_share(fr[31:16], slot_gain[v], gr);
            slot_pos[v] = (slot_pos[v] + 1) % SampleDepth;
            slot_left[v]--;
            if (slot_left[v] == 0) slot_on[v] = 1'b0;
          end
        end
        f.mix_left = clamp16(acc_l);
        f.mix_right = clamp16(acc_r);
      end
      default: ;
    endcase
    return f;
  endfunction

  function automatic logic [95:0] pack_item(mix_item_t it);
    return {5'd0, it.voice_pan, it.voice_volume, it.voice_length,
            it.sample_right, it.sample_left, it.address, it.mode};
  endfunction

  // one input transfer; predicted or typed frame queued on acceptance
  task automatic send_item(mix_item_t it, bit typed, mix_frame_t typed_frame);
    int gap;
    mix_frame_t f;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= pack_item(it);
    do @(posedge clk); while (!in_tready);
    f = mixer_step(it);
    frames_due.push_back(typed ? typed_frame : f);
  endtask

  // register write once the block has drained
  task automatic set_master(logic [15:0] val);
    in_tvalid <= 1'b0;
    wait (frames_due.size() == 0);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    master_gain = val;
  endtask

  function automatic mix_item_t random_item();
    mix_item_t it;
    int r, off, room;
    it = '0;
    it.sample_left = 16'($urandom);
    it.sample_right = 16'($urandom);
    r = $urandom_range(99);
    it.mode = (r < 45) ? MODE_MIX : (r < 70) ? MODE_START : (r < 95) ? MODE_LOAD : MODE_NONE;
    // voices start and end inside the filled window
    off = $urandom_range(FillFrames - 1);
    room = FillFrames - off;
    it.address = (it.mode == MODE_START) ? 12'(FillBase + off) : 12'($urandom);
    r = $urandom_range(99);
    if (r < 6) it.voice_length = 0;
    else if (r < 50) it.voice_length = 13'($urandom_range((room < 32) ? room : 32, 1));
    else it.voice_length = 13'($urandom_range(room, 1));
    it.voice_volume = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(32768));
    r = $urandom_range(9);
    it.voice_pan = (r == 0) ? 16'h8000 : (r == 1) ? 16'h7fff : (r == 2) ? 16'h0000
                 : 16'($urandom);
    return it;
  endfunction

  // result side: random stalls and field compare
  always @(posedge clk) begin
    mix_frame_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_hold <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[33:0];
        if (frames_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer %h", got);
        end else begin
          want = frames_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: left %h/%h right %h/%h playing %b/%b started %b/%b",
                       want.mix_left, got.mix_left, want.mix_right, got.mix_right,
                       want.playing, got.playing, want.started, got.started);
          end
        end
      end
      out_tready <= (rx_hold == 0);
      rx_hold <= (rx_hold == 0) ? pick_gap() : rx_hold - 1;
    end
  end

  table_row_t dir_rows [25] = '{
    '{MODE_NONE, 12'hfff, 16'hffff, 16'hffff, 13'h1fff, 16'hffff, 16'hffff, 1, 34'd0},
    '{MODE_LOAD, 12'd0, 16'h7fff, 16'h8000, 13'd0, 16'd0, 16'd0, 1, 34'd0},
    '{MODE_LOAD, 12'd4095, 16'h8000, 16'h7fff, 13'd0, 16'd0, 16'd0, 1, 34'd0},
    '{MODE_LOAD, 12'd1, 16'hffff, 16'h0001, 13'd0, 16'd0, 16'd0, 1, 34'd0},
    '{MODE_START, 12'd0, 16'd0, 16'd0, 13'd0, 16'd32768, 16'd0, 1, 34'd0},
    '{MODE_START, 12'd0, 16'd0, 16'd0, 13'd2, 16'd32768, 16'd0, 1, {1'b1, 1'b0, 32'd0}},
    '{MODE_MIX, 12'd0, 16'd0, 16'd0, 13'd0, 16'd0, 16'd0, 0, 34'd0},
    '{MODE_MIX, 12'd0, 16'd0, 16'd0, 13'd0, 16'd0, 16'd0, 0, 34'd0},
    '{MODE_START, 12'd4095, 16'd0, 16'd0, 13'd3, 16'hffff, 16'h7fff, 0, 34'd0},
    '{MODE_START, 12'd1, 16'd0, 16'd0, 13'd5, 16'd32768, 16'h8000, 0, 34'd0},
    '{MODE_START, 12'd2, 16'd0, 16'd0, 13'd4, 16'd0, 16'hffff, 0, 34'd0},
    '{MODE_START, 12'd4090, 16'd0, 16'd0, 13'd9, 16'd20000, 16'h0001, 0, 34'd0},
    '{MODE_START, 12'd3, 16'd0, 16'd0, 13'd6, 16'd32767, 16'h8001, 0, 34'd0},
    '{MODE_START, 12'd7, 16'd0, 16'd0, 13'd7, 16'd12345, 16'h4000, 0, 34'd0},
    '{MODE_START, 12'd9, 16'd0, 16'd0, 13'h1fff, 16'hffff, 16'h8000, 0, 34'd0},
    '{MODE_START, 12'd9, 16'd0, 16'd0, 13'd4096, 16'hffff, 16'h8000, 0, 34'd0},
    '{MODE_MIX, 12'd0, 16'd0, 16'd0, 13'd0, 16'd0, 16'd0, 0, 34'd0},
    '{MODE_MIX, 12'd0, 16'd0, 16'd0, 13'd0, 16'd0, 16'd0, 0, 34'd0},
    '{MODE_NONE, 12'd5, 16'h1234, 16'h5678, 13'd3, 16'd1, 16'd1, 1, {1'b0, 1'b1, 32'd0}},
    '{MODE_MIX, 12'd0, 16'd0, 16'd0, 13'd0, 16'd0, 16'd0, 0, 34'd0},
    '{MODE_MIX, 12'd0, 16'd0, 16'd0, 13'd0, 16'd0, 16'd0, 0, 34'd0},
    '{MODE_MIX, 12'd0, 16'd0, 16'd0, 13'd0, 16'd0, 16'd0, 0, 34'd0},
    '{MODE_MIX, 12'd0, 16'd0, 16'd0, 13'd0, 16'd0, 16'd0, 0, 34'd0},
    '{MODE_MIX, 12'd0, 16'd0, 16'd0, 13'd0, 16'd0, 16'd0, 0, 34'd0},
    '{MODE_MIX, 12'd0, 16'd0, 16'd0, 13'd0, 16'd0, 16'd0, 0, 34'd0}
  };

  logic [15:0] phase_gain [6] = '{16'd0, 16'hffff, 16'd1, 16'd16384, 16'd32768, 16'd0};

  // main sequence
  initial begin
    mix_item_t it;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // fill the window around the wrap point; every voice stays inside it
    for (int a = 0; a < FillFrames; a++) begin
      it = '0;
      it.mode = MODE_LOAD;
      it.address = 12'(FillBase + a);
      it.sample_left = 16'($urandom);
      it.sample_right = 16'($urandom);
      send_item(it, 0, '0);
    end
    set_master(16'd32768);
    foreach (dir_rows[i]) begin
      it.mode = dir_rows[i].mode;
      it.address = dir_rows[i].address;
      it.sample_left = dir_rows[i].sample_left;
      it.sample_right = dir_rows[i].sample_right;
      it.voice_length = dir_rows[i].voice_length;
      it.voice_volume = dir_rows[i].voice_volume;
      it.voice_pan = dir_rows[i].voice_pan;
      send_item(it, dir_rows[i].typed, dir_rows[i].frame);
    end
    // random phases, each under its own master gain
    for (int p = 0; p < 6; p++) begin
      set_master((p == 5) ? 16'($urandom) : phase_gain[p]);
      steady = (p % 3 == 2);
      repeat (55) send_item(random_item(), 0, '0);
    end
    in_tvalid <= 1'b0;
    wait (frames_due.size() == 0);
    repeat (40) @(posedge clk);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire

// ===== stereo_voice_mixer.f =====
+incdir+sv
sv/svm_pkg.sv
sv/svm_cell.sv
sv/svm_mac.sv
sv/stereo_voice_mixer.sv
bench/stereo_voice_mixer_test.sv
